>>> rtl/usd_pkg.sv
package usd_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

    // one queued entry: the results that one input byte causes
    // pair: a replacement character goes out first, then cp/bad with last set
    typedef struct packed {
        logic            pair;
        logic [CP_W-1:0] cp;
        logic            bad;
    } usd_item_t;

endpackage

>>> rtl/usd_front.sv
module usd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               q_full,
    output logic               in_ready,
    output logic               q_push,
    output usd_pkg::usd_item_t q_item
);
    import usd_pkg::*;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic            bad;
        logic [1:0]      pend;
        logic [CP_W-1:0] pval;
    } lead_t;

    logic            reject_reg;
    logic [1:0]      pend_reg, pend_next;
    logic [CP_W-1:0] pval_reg, pval_next;
    lead_t           lead;
    logic            is_cont;
    logic            emit;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] pval_shift;
    logic            take;

    function automatic lead_t decode_lead(input logic [7:0] b, input logic reject);
        lead_t r;
        r.emit = 1'b0;
        r.cp   = '0;
        r.bad  = 1'b0;
        r.pend = 2'd0;
        r.pval = '0;
        if (b[7] == 1'b0) begin
            r.emit = 1'b1;
            r.cp   = {{(CP_W-8){1'b0}}, b};
        end else if (b[6] == 1'b0) begin
            r.emit = 1'b1;
            r.cp   = REPLACEMENT_CHAR;
            r.bad  = 1'b1;
        end else if (b[5] == 1'b0) begin
            r.pend = 2'd1;
            r.pval = {{(CP_W-5){1'b0}}, b[4:0]};
        end else if (b[4] == 1'b0) begin
            r.pend = 2'd2;
            r.pval = {{(CP_W-4){1'b0}}, b[3:0]};
        end else if (b[3] == 1'b1 && reject) begin
            r.emit = 1'b1;
            r.cp   = REPLACEMENT_CHAR;
            r.bad  = 1'b1;
        end else begin
            r.pend = 2'd3;
            r.pval = {{(CP_W-3){1'b0}}, b[2:0]};
        end
        return r;
    endfunction

    assign lead       = decode_lead(in_byte, reject_reg);
    assign is_cont    = (in_byte[7:6] == 2'b10);
    assign pend_dec   = pend_reg - 2'd1;
    assign pval_shift = {pval_reg[CP_W-7:0], in_byte[5:0]};
    assign in_ready   = !q_full;
    assign take       = in_valid && in_ready;
    assign q_push     = take && emit;

    always_comb begin
        emit      = 1'b0;
        q_item    = '0;
        pend_next = pend_reg;
        pval_next = pval_reg;
        if (pend_reg == 2'd0) begin
            emit      = lead.emit;
            q_item.cp  = lead.cp;
            q_item.bad = lead.bad;
            pend_next = lead.pend;
            pval_next = lead.pval;
        end else if (is_cont) begin
            pend_next = pend_dec;
            if (pend_dec == 2'd0) begin
                emit       = 1'b1;
                q_item.cp  = pval_shift;
                pval_next  = '0;
            end else begin
                pval_next = pval_shift;
            end
        end else begin
            // sequence broken: replacement, then the byte restarts as a lead
            emit      = 1'b1;
            pend_next = lead.pend;
            pval_next = lead.pval;
            if (lead.emit) begin
                q_item.pair = 1'b1;
                q_item.cp   = lead.cp;
                q_item.bad  = lead.bad;
            end else begin
                q_item.cp  = REPLACEMENT_CHAR;
                q_item.bad = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_reg <= 1'b1;
            pend_reg   <= 2'd0;
            pval_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                reject_reg <= cfg_wr_data;
            end
            if (take) begin
                pend_reg <= pend_next;
                pval_reg <= pval_next;
            end
        end
    end

endmodule

>>> rtl/usd_queue.sv
module usd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  usd_pkg::usd_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output usd_pkg::usd_item_t head
);
    import usd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    usd_item_t     slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/usd_back.sv
module usd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  usd_pkg::usd_item_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [usd_pkg::CP_W-1:0] out_cp,
    output logic               out_bad,
    output logic               out_last
);
    import usd_pkg::*;

    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            bad_reg;
    logic            last_reg;
    logic            second_reg;
    logic [CP_W-1:0] second_cp_reg;
    logic            second_bad_reg;
    logic            load;

    assign load  = !valid_reg || out_ready;
    assign q_pop = load && !second_reg && !q_empty;

    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_bad   = bad_reg;
    assign out_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (load) begin
            if (second_reg) begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
                cp_reg     <= second_cp_reg;
                bad_reg    <= second_bad_reg;
                last_reg   <= 1'b1;
            end else if (!q_empty) begin
                valid_reg <= 1'b1;
                if (q_head.pair) begin
                    cp_reg         <= REPLACEMENT_CHAR;
                    bad_reg        <= 1'b1;
                    last_reg       <= 1'b0;
                    second_reg     <= 1'b1;
                    second_cp_reg  <= q_head.cp;
                    second_bad_reg <= q_head.bad;
                end else begin
                    cp_reg   <= q_head.cp;
                    bad_reg  <= q_head.bad;
                    last_reg <= 1'b1;
                end
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/utf8_stream_decoder.sv
// path: a byte that completes a character has its result written to the entry queue and
//   then registered in the output stage, which offers it
// throughput: one byte per cycle while the entry queue is not full; a byte that breaks a
//   sequence and yields two results is absorbed by the entry queue (QUEUE_DEPTH entries)
// reset: synchronous active-low aresetn clears decode state, queue and output;
//   reject_high_leads returns to 1
module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: reject_high_leads
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    // decoded output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // [0] malformed
    output logic        m_axis_tlast    // last result caused by one input byte
);
    import usd_pkg::*;

    usd_item_t       push_item;
    usd_item_t       head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic [CP_W-1:0] out_cp;

    // front: decode state and byte classification, one byte per transfer
    usd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_byte     (s_axis_tdata),
        .q_full      (q_full),
        .in_ready    (s_axis_tready),
        .q_push      (push),
        .q_item      (push_item)
    );

    // entries between front and back, so each side stalls on its own
    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    // back: expands each entry into one or two output transfers
    usd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cp    (out_cp),
        .out_bad   (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_cp};

endmodule

>>> tb/utf8_stream_decoder_tb.sv
module utf8_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import usd_pkg::*;

    localparam int unsigned BYTE_TARGET = 600;   // random bytes, roughly
    localparam int unsigned PHASES      = 6;
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no transfer at all
    localparam int unsigned SETTLE      = 8;     // cycles for in-flight bytes to finish

    // one decoded character as it should leave the block
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            last;
    } cp_result_t;

    // decoder state tracking plus the queue of characters still owed by the block
    class code_point_tracker;
        bit              strict_leads;
        logic [1:0]      seq_left;
        logic [CP_W-1:0] seq_value;
        cp_result_t      owed[$];
        int              emitted_now;
        int              errors;
        int              bytes_seen;
        int              cps_checked;
        int              bad_checked;

        function new();
            strict_leads = 1'b1;
            seq_left     = '0;
            seq_value    = '0;
            errors       = 0;
            bytes_seen   = 0;
            cps_checked  = 0;
            bad_checked  = 0;
        endfunction

        function void set_strict(bit v);
            strict_leads = v;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // append a result; only the final one caused by a byte carries last
        function void emit(logic [CP_W-1:0] cp, logic bad);
            cp_result_t r;
            if (emitted_now > 0)
                owed[owed.size()-1].last = 1'b0;
            r.cp   = cp;
            r.bad  = bad;
            r.last = 1'b1;
            owed.push_back(r);
            emitted_now++;
        endfunction

        // byte seen with nothing pending
        function void decode_lead(logic [7:0] b);
            if (b < 8'h80) begin
                emit({13'd0, b}, 1'b0);
            end else if (b < 8'hC0) begin
                emit(REPLACEMENT_CHAR, 1'b1);       // stray continuation
            end else if (b < 8'hE0) begin
                seq_left  = 2'd1;
                seq_value = {16'd0, b[4:0]};
            end else if (b < 8'hF0) begin
                seq_left  = 2'd2;
                seq_value = {17'd0, b[3:0]};
            end else if (b >= 8'hF8 && strict_leads) begin
                emit(REPLACEMENT_CHAR, 1'b1);       // high lead rejected
            end else begin
                seq_left  = 2'd3;
                seq_value = {18'd0, b[2:0]};
            end
        endfunction

        // called for every accepted input transfer
        function void note_byte(logic [7:0] b);
            emitted_now = 0;
            bytes_seen++;
            if (seq_left == 2'd0) begin
                decode_lead(b);
            end else if (b[7:6] == 2'b10) begin
                seq_value = {seq_value[CP_W-7:0], b[5:0]};
                seq_left  = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                    emit(seq_value, 1'b0);
                    seq_value = '0;
                end
            end else begin
                // broken sequence: replacement first, then the byte starts over
                seq_left  = '0;
                seq_value = '0;
                emit(REPLACEMENT_CHAR, 1'b1);
                decode_lead(b);
            end
        endfunction

        // called for every accepted output transfer
        function void check_result(logic [CP_W-1:0] cp, logic bad, logic last);
            cp_result_t want;
            if (owed.size() == 0) begin
                $error("unexpected result: code_point=%h malformed=%b last=%b", cp, bad, last);
                errors++;
                return;
            end
            want = owed.pop_front();
            cps_checked++;
            if (want.bad)
                bad_checked++;
            if (cp !== want.cp) begin
                $error("code_point mismatch: expected %h, got %h", want.cp, cp);
                errors++;
            end
            if (bad !== want.bad) begin
                $error("malformed mismatch: expected %b, got %b", want.bad, bad);
                errors++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [20:0] code_point, [23:21] zero
    logic        m_axis_tuser;     // [0] malformed
    logic        m_axis_tlast;     // last result of one input byte

    code_point_tracker cps;

    // idling controls shared between the sender, the receiver and the sequence
    bit tx_steady;
    bit rx_steady;
    bit hold_off_req;
    int quiet_cycles;
    int hold_offs_done;

    // hand-picked bytes while high leads are rejected
    logic [7:0] strict_bytes[$] = '{
        8'h00, 8'h7F,                 // ascii extremes
        8'h80, 8'hBF,                 // stray continuations
        8'hC2, 8'hA9,                 // two-byte character
        8'hE2, 8'h82, 8'hAC,          // three-byte character
        8'hF0, 8'h9F, 8'h98, 8'h80,   // four-byte character
        8'hF8, 8'hFF,                 // rejected high leads
        8'hC3, 8'h41,                 // broken by ascii: two results
        8'hF0, 8'hFF                  // broken by a rejected high lead: two results
    };

    // hand-picked bytes with high leads decoded as four-byte leads
    logic [7:0] lenient_bytes[$] = '{
        8'hE2, 8'h82, 8'hFA,          // broken by a high lead, which opens a new sequence
        8'h88, 8'h80, 8'h80,
        8'hFF, 8'hBF, 8'hBF, 8'hBF    // largest value, all 21 bits set
    };

    utf8_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // any byte that is not a continuation: ascii or a lead
    function automatic logic [7:0] pick_breaker();
        int v;
        v = $urandom_range(0, 191);
        if (v >= 128)
            v = v + 64;
        return v[7:0];
    endfunction

    function automatic logic [7:0] pick_continuation();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // a lead opening a sequence of len bytes, len 2..4
    function automatic logic [7:0] pick_lead(int len, bit lenient);
        case (len)
            2: begin
                return {3'b110, 5'($urandom_range(0, 31))};
            end
            3: begin
                return {4'b1110, 4'($urandom_range(0, 15))};
            end
            default: begin
                if (lenient && $urandom_range(0, 2) == 0)
                    return {5'b11111, 3'($urandom_range(0, 7))};
                return {5'b11110, 3'($urandom_range(0, 7))};
            end
        endcase
    endfunction

    // offer one byte after a random gap and return once it is transferred
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        cps.note_byte(b);
    endtask

    // one random character, a broken sequence or line noise; returns bytes sent
    task automatic send_unit(input bit lenient, output int sent);
        int roll;
        int len;
        int keep;
        roll = $urandom_range(0, 99);
        sent = 0;
        if (roll < 15) begin
            send_byte(8'($urandom_range(0, 255)));
            sent = 1;
        end else if (roll < 27) begin
            // sequence cut short by a byte that is no continuation
            len  = $urandom_range(2, 4);
            keep = $urandom_range(0, len - 2);
            send_byte(pick_lead(len, lenient));
            repeat (keep) send_byte(pick_continuation());
            send_byte(pick_breaker());
            sent = keep + 2;
        end else begin
            len = $urandom_range(1, 4);
            if (len == 1)
                send_byte(8'($urandom_range(0, 127)));
            else
                send_byte(pick_lead(len, lenient));
            repeat (len - 1) send_byte(pick_continuation());
            sent = len;
        end
    endtask

    // let every owed result arrive, then give the pipeline time to go quiet
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (cps.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_lead_mode(input bit strict);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= strict;
        cps.set_strict(strict);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
                hold_offs_done++;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(rx_steady);
            end
        end
    end

    // every output transfer is checked against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            cps.check_result(m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
    end

    // watchdog: too long without any transfer means the block is stuck
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[utf8_stream_decoder] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sent;
        int phase_bytes;
        int phase_target;
        cps            = new();
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        hold_off_req   = 1'b0;
        quiet_cycles   = 0;
        hold_offs_done = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;

        // synchronous reset, held low and then released
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: strict high leads
        write_lead_mode(1'b1);
        foreach (strict_bytes[i])
            send_byte(strict_bytes[i]);
        wait_drained();

        // directed: lenient high leads
        write_lead_mode(1'b0);
        foreach (lenient_bytes[i])
            send_byte(lenient_bytes[i]);
        wait_drained();

        // random phases, alternating lead mode and varying the idling style
        phase_target = BYTE_TARGET / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            write_lead_mode(p[0]);
            tx_steady   = (p == 2);
            rx_steady   = (p == 3);
            phase_bytes = 0;
            if (p == 4) begin
                // receiver holds off while bytes keep coming, so the entry queue fills
                hold_off_req = 1'b1;
                tx_steady    = 1'b1;
                while (phase_bytes < 40) begin
                    send_unit(1'b0, sent);
                    phase_bytes += sent;
                end
                tx_steady = 1'b0;
            end
            while (phase_bytes < phase_target) begin
                send_unit(!p[0], sent);
                phase_bytes += sent;
            end
            wait_drained();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        if (cps.outstanding() != 0) begin
            $error("%0d results never arrived", cps.outstanding());
            cps.errors++;
        end

        $display("covered %0d input bytes and %0d decoded results, %0d of them replacements,",
                 cps.bytes_seen, cps.cps_checked, cps.bad_checked);
        $display("in both lead modes, with %0d long output hold-off(s)", hold_offs_done);
        if (cps.errors == 0) begin
            $display("[utf8_stream_decoder] OK");
        end else begin
            $display("[utf8_stream_decoder] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/usd_pkg.sv
rtl/usd_front.sv
rtl/usd_queue.sv
rtl/usd_back.sv
rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
